// File: rtl/ramp_breakpoint_extractor_core_defines.svh
// Assertion helpers for the ramp breakpoint extractor.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef RAMP_BREAKPOINT_EXTRACTOR_CORE_DEFINES_SVH
`define RAMP_BREAKPOINT_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define RBE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rbe_pkg.sv
`default_nettype none
package rbe_pkg;

	localparam int TICK_W    = 32;
	localparam int VAL_W     = 24;
	localparam int US_W      = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 64;
	localparam int NSLOT     = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT   = 1'd1;

	localparam logic [CFG_W-1:0] TICK_LENGTH_RST = 32'd341333;
	localparam logic [CFG_W-1:0] GAP_LIMIT_RST   = 32'd333000;

	// result slots of one beat group, emitted in this order
	localparam int SLOT_HEAD = 0;
	localparam int SLOT_TAIL = 1;
	localparam int SLOT_END  = 2;

	typedef enum logic [1:0] {
		KIND_FIRST = 2'd0,
		KIND_RAMP  = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// how much of the chunk has been seen
	typedef enum logic [2:0] {
		SEEN_NONE = 3'b001,
		SEEN_ONE  = 3'b010,
		SEEN_TWO  = 3'b100
	} seen_t;

	typedef struct packed {
		logic [TICK_W-1:0]       tick;
		logic signed [VAL_W-1:0] value;
		logic [US_W-1:0]         rdur;
		logic                    last;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] tick_length;
		logic [CFG_W-1:0] gap_limit;
	} cfg_t;

	// span: tick difference for a ramp before scaling, microseconds after
	typedef struct packed {
		kind_t                   kind;
		logic [TICK_W-1:0]       start;
		logic [US_W-1:0]         span;
		logic signed [VAL_W-1:0] value;
	} res_t;

	typedef struct packed {
		logic [NSLOT-1:0] vld;
		res_t [NSLOT-1:0] slot;
	} group_t;

endpackage
`default_nettype wire

// File: rtl/ramp_breakpoint_extractor_core.sv
// Channel  | Signals                                             | Beat on
// ---------+-----------------------------------------------------+-----------------------
// in       | sample_tick target_value ramp_duration chunk_end    | in_valid && in_ready
// out      | result_kind start_tick duration_us end_value        | out_valid && out_ready
//          | last_result                                         |
// cfg      | cfg_index cfg_wdata                                 | cfg_we
//
// One input beat per cycle when each sample yields at most one result and out_ready is
// high; an output register group releases one result per cycle while out_ready is high,
// so a sample with two or three results holds the input until its group has drained; input,
// track and output registers lie on the path. arst_n clears chunk state and restores
// tick_length and gap_limit. Output stalls back up stage by stage; bubbles in the pipe still take input.
`default_nettype none
module ramp_breakpoint_extractor_core import rbe_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [TICK_W-1:0]    sample_tick,
	input  wire logic signed [VAL_W-1:0] target_value,
	input  wire logic [US_W-1:0]      ramp_duration,
	input  wire logic                 chunk_end,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                result_kind,
	output logic [TICK_W-1:0]         start_tick,
	output logic [US_W-1:0]           duration_us,
	output logic signed [VAL_W-1:0]   end_value,
	output logic                      last_result
);

	// configuration; the user must write it only while idle, the block does not enforce this
	cfg_t   cfg_q;

	// input register
	logic   v_s1;
	item_t  item_s1;

	logic   trk_ready;
	logic   grp_valid;
	logic   grp_ready;
	group_t grp_raw;
	group_t grp_scaled;
	kind_t  kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_length <= TICK_LENGTH_RST;
			cfg_q.gap_limit   <= GAP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TICK_LENGTH: cfg_q.tick_length <= cfg_wdata;
				CFG_GAP_LIMIT:   cfg_q.gap_limit   <= cfg_wdata;
			endcase
		end
	end

	assign in_ready = !v_s1 || trk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{sample_tick, target_value, ramp_duration, chunk_end};
		end
	end

	// chunk state, extreme and gap decisions
	rbe_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s1),
		.item_ready (trk_ready),
		.item       (item_s1),
		.cfg        (cfg_q),
		.grp_valid  (grp_valid),
		.grp_ready  (grp_ready),
		.grp        (grp_raw)
	);

	// tick spans to microseconds
	rbe_scale u_scale (
		.raw         (grp_raw),
		.tick_length (cfg_q.tick_length),
		.scaled      (grp_scaled)
	);

	// one result beat per cycle out of each group while out_ready is high
	rbe_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp_scaled),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_kind  (kind),
		.out_start (start_tick),
		.out_dur   (duration_us),
		.out_value (end_value),
		.out_last  (last_result)
	);

	assign result_kind = kind;

endmodule
`default_nettype wire

// File: rtl/rbe_track.sv
`default_nettype none
`include "ramp_breakpoint_extractor_core_defines.svh"
module rbe_track import rbe_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   item_valid,
	output logic        item_ready,
	input  wire item_t  item,
	input  wire cfg_t   cfg,
	output logic        grp_valid,
	input  wire logic   grp_ready,
	output group_t      grp
);

	seen_t                   seen_q, seen_n;
	logic signed [VAL_W-1:0] prev_q, prev_n;
	logic signed [VAL_W-1:0] hv_q, hv_n;
	logic [TICK_W-1:0]       ht_q, ht_n;
	logic                    bld_q, bld_n;
	logic [TICK_W-1:0]       seg_q, seg_n;

	logic                    v_s2;
	group_t                  grp_s2;
	group_t                  g;

	logic                    take;
	logic [TICK_W-1:0]       ndiff;
	logic [PROD_W-1:0]       gap_prod;
	logic                    row;
	logic                    ext;

	assign item_ready = !v_s2 || grp_ready;
	assign take       = item_valid && item_ready;
	assign grp_valid  = v_s2;
	assign grp        = grp_s2;

	// gap to the incoming sample, compared in Q16.16 microseconds
	assign ndiff    = item.tick - ht_q;
	assign gap_prod = {{(PROD_W-TICK_W){1'b0}}, ndiff} * {{(PROD_W-CFG_W){1'b0}}, cfg.tick_length};
	assign row      = gap_prod > {{(PROD_W-CFG_W-FRAC_W){1'b0}}, cfg.gap_limit, {FRAC_W{1'b0}}};

	// strict local extreme of the held sample
	assign ext = (hv_q > prev_q && hv_q > item.value) || (hv_q < prev_q && hv_q < item.value);

	always_comb begin
		seen_n = seen_q;
		prev_n = prev_q;
		hv_n   = hv_q;
		ht_n   = ht_q;
		bld_n  = bld_q;
		seg_n  = seg_q;
		g      = '0;
		unique case (seen_q)
			SEEN_NONE: begin
				g.vld[SLOT_HEAD]  = 1'b1;
				g.slot[SLOT_HEAD] = '{KIND_FIRST, item.tick, item.rdur, item.value};
				seen_n            = SEEN_ONE;
			end
			SEEN_ONE, SEEN_TWO: begin
				if (seen_q == SEEN_TWO) begin
					if (!bld_q) begin
						bld_n = 1'b1;
						seg_n = ht_q;
					end else begin
						if (ext || row) begin
							g.vld[SLOT_HEAD]  = 1'b1;
							g.slot[SLOT_HEAD] = '{KIND_RAMP, seg_q, ht_q - seg_q, hv_q};
						end
						bld_n = !row;
						if (!row && ext) begin
							seg_n = ht_q;
						end
					end
				end
				prev_n = hv_q;
				seen_n = SEEN_TWO;
			end
			default: begin
				seen_n = SEEN_NONE;
			end
		endcase
		ht_n = item.tick;
		hv_n = item.value;
		if (item.last) begin
			// final sample closes an open ramp at itself
			if (seen_n == SEEN_TWO && bld_n) begin
				g.vld[SLOT_TAIL]  = 1'b1;
				g.slot[SLOT_TAIL] = '{KIND_RAMP, seg_n, item.tick - seg_n, item.value};
			end
			g.vld[SLOT_END]  = 1'b1;
			g.slot[SLOT_END] = '{KIND_END, '0, '0, '0};
			seen_n = SEEN_NONE;
			prev_n = '0;
			hv_n   = '0;
			ht_n   = '0;
			bld_n  = 1'b0;
			seg_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
			prev_q <= '0;
			hv_q   <= '0;
			ht_q   <= '0;
			bld_q  <= 1'b0;
			seg_q  <= '0;
			v_s2   <= 1'b0;
		end else begin
			if (take) begin
				seen_q <= seen_n;
				prev_q <= prev_n;
				hv_q   <= hv_n;
				ht_q   <= ht_n;
				bld_q  <= bld_n;
				seg_q  <= seg_n;
			end
			if (item_ready) begin
				v_s2 <= take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp_s2 <= g;
		end
	end

	`RBE_ASSERT_IMP(a_build_needs_pair, bld_q, seen_q == SEEN_TWO, "ramp open without held pair")
	`RBE_ASSERT_NXT(a_end_clears, take && item.last, seen_q == SEEN_NONE && !bld_q, "chunk not cleared")
	`RBE_ASSERT_IMP(a_tail_has_end, v_s2 && grp_s2.vld[SLOT_TAIL], grp_s2.vld[SLOT_END], "tail ramp without end")

endmodule
`default_nettype wire

// File: rtl/rbe_scale.sv
`default_nettype none
module rbe_scale import rbe_pkg::*; (
	input  wire group_t           raw,
	input  wire logic [CFG_W-1:0] tick_length,
	output group_t                scaled
);

	logic [PROD_W-1:0] prod [SLOT_END];

	// ticks times Q16.16 length, truncated, saturated to 32 bits
	always_comb begin
		scaled = raw;
		for (int i = 0; i < SLOT_END; i++) begin
			prod[i] = {{(PROD_W-US_W){1'b0}}, raw.slot[i].span}
				* {{(PROD_W-CFG_W){1'b0}}, tick_length};
			if (raw.slot[i].kind == KIND_RAMP) begin
				if (prod[i][PROD_W-1:US_W+FRAC_W] != '0) begin
					scaled.slot[i].span = '1;
				end else begin
					scaled.slot[i].span = prod[i][US_W+FRAC_W-1:FRAC_W];
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/rbe_emit.sv
`default_nettype none
`include "ramp_breakpoint_extractor_core_defines.svh"
module rbe_emit import rbe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              grp_valid,
	output logic                   grp_ready,
	input  wire group_t            grp,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kind_t                  out_kind,
	output logic [TICK_W-1:0]      out_start,
	output logic [US_W-1:0]        out_dur,
	output logic signed [VAL_W-1:0] out_value,
	output logic                   out_last
);

	logic [NSLOT-1:0] vld_q;
	res_t [NSLOT-1:0] slot_q;
	logic [NSLOT-1:0] sel;
	logic [1:0]       idx;
	logic [NSLOT-1:0] rem;
	logic             fire;
	res_t             cur;

	always_comb begin
		priority if (vld_q[SLOT_HEAD]) begin
			sel = NSLOT'(1) << SLOT_HEAD;
			idx = 2'(SLOT_HEAD);
		end else if (vld_q[SLOT_TAIL]) begin
			sel = NSLOT'(1) << SLOT_TAIL;
			idx = 2'(SLOT_TAIL);
		end else begin
			sel = NSLOT'(1) << SLOT_END;
			idx = 2'(SLOT_END);
		end
	end

	assign out_valid = |vld_q;
	assign fire      = out_valid && out_ready;
	assign rem       = vld_q & ~(fire ? sel : '0);
	assign grp_ready = (rem == '0);

	assign cur       = slot_q[idx];
	assign out_kind  = cur.kind;
	assign out_start = cur.start;
	assign out_dur   = cur.span;
	assign out_value = cur.value;
	assign out_last  = (cur.kind == KIND_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (grp_ready) begin
			vld_q <= grp_valid ? grp.vld : '0;
		end else begin
			vld_q <= rem;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			slot_q <= grp.slot;
		end
	end

	`RBE_ASSERT_IMP(a_end_drains, fire && out_last, rem == '0, "end marker not last of group")
	`RBE_ASSERT_IMP(a_first_alone, out_valid && out_kind == KIND_FIRST, !vld_q[SLOT_TAIL], "pass-through with tail ramp")

endmodule
`default_nettype wire
